// ----- src/smacc_pkg.sv -----
// shared types and constants of the sign-magnitude accumulator alu
package smacc_pkg;

	localparam int WORD_W = 8;
	localparam int MAG_W  = WORD_W - 1;
	localparam int CNT_W  = $clog2(MAG_W);
	localparam int FUNC_W = 4;
	localparam int ADDR_W = 3;

	typedef enum logic [FUNC_W-1:0] {
		F_ADD = 4'd0,
		F_SUB = 4'd1,
		F_MUL = 4'd2,
		F_DIV = 4'd3,
		F_AND = 4'd4,
		F_NOT = 4'd5,
		F_OR  = 4'd6,
		F_XOR = 4'd7,
		F_LD  = 4'd8,
		F_ST  = 4'd9,
		F_WR  = 4'd10,
		F_CLR = 4'd11
	} func_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] wdata;
	} cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] acc_value;
		logic [WORD_W-1:0] mem_value;
		logic              overflow;
		logic              underflow;
		logic              div_zero;
	} res_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              ovf;
		logic              udf;
	} ser_res_t;

endpackage

// ----- src/sign_magnitude_accumulator_alu.sv -----
// top level of the sign-magnitude accumulator alu
// Accumulator machine on 8-bit sign-magnitude words (bit 7 sign, bits 6..0
// magnitude) with a small data memory. A command on the cmd channel carries
// func, addr and wdata; each command gives exactly one result on the res
// channel with the accumulator and the addressed memory word after the step,
// plus overflow, underflow and divide-by-zero flags.
// A transfer takes place when valid is high and stall is low at a rising edge.
// Logic, load, store, memory write, clear, unused codes and divide by zero
// pass through the exec and done states; add, sub, mul and div also pass
// through the calc state, where the 7-step bit-serial arithmetic unit works.
// One command is worked on at a time and the next one can be taken in the
// cycle after the result is loaded.
// cmd_stall is high from a transfer until the result has been moved into the
// output register; a new command is taken while that result still waits.
// If res_stall holds, the next result waits in the block and res keeps its
// value until its transfer.
// Reset clears the accumulator and every memory word to zero.
module sign_magnitude_accumulator_alu #(
	parameter int MEM_DEPTH = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  smacc_pkg::cmd_t cmd,
	output logic            res_valid,
	input  logic            res_stall,
	output smacc_pkg::res_t res
);
	import smacc_pkg::*;

	localparam int ADDR_SPAN  = 1 << ADDR_W;
	localparam int LIVE_DEPTH = (MEM_DEPTH < ADDR_SPAN) ? MEM_DEPTH : ADDR_SPAN;
	localparam int IDX_W      = $clog2(LIVE_DEPTH);

	typedef logic [IDX_W-1:0] idx_t;
	typedef idx_t [ADDR_SPAN-1:0] wrap_t;

	function automatic wrap_t build_wrap();
		wrap_t t;
		for (int i = 0; i < ADDR_SPAN; i++) begin
			t[i] = idx_t'(i % MEM_DEPTH);
		end
		return t;
	endfunction

	localparam wrap_t WRAP = build_wrap();

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_CALC = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t            state_q;
	logic [WORD_W-1:0] acc_q;
	logic              res_valid_q;
	res_t              res_q;
	logic [FUNC_W-1:0] func_q;
	idx_t              idx_q;
	logic [WORD_W-1:0] wdata_q;
	logic [WORD_W-1:0] mem_q;
	logic              ovf_q;
	logic              udf_q;
	logic              dz_q;

	logic              accept;
	logic              can_load;
	func_t             fn;
	logic [WORD_W-1:0] m;
	logic [WORD_W-1:0] acc_next;
	logic [WORD_W-1:0] mem_next;
	logic              arith_go;
	logic              dz_cond;
	logic              wr_en;
	logic [WORD_W-1:0] wr_data;
	logic              ser_start;
	logic              ser_done;
	ser_res_t          ser_res;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign can_load  = !res_valid_q || !res_stall;
	assign fn        = func_t'(func_q);

	always_comb begin
		acc_next = acc_q;
		mem_next = m;
		arith_go = 1'b0;
		dz_cond  = 1'b0;
		wr_en    = 1'b0;
		wr_data  = wdata_q;
		unique case (fn)
			F_ADD, F_SUB, F_MUL: arith_go = 1'b1;
			F_DIV: begin
				dz_cond  = ~|m[MAG_W-1:0];
				arith_go = ~dz_cond;
			end
			F_AND: acc_next = acc_q & m;
			F_NOT: acc_next = ~acc_q;
			F_OR:  acc_next = acc_q | m;
			F_XOR: acc_next = acc_q ^ m;
			F_LD:  acc_next = m;
			F_ST: begin
				wr_en    = 1'b1;
				wr_data  = acc_q;
				mem_next = acc_q;
			end
			F_WR: begin
				wr_en    = 1'b1;
				mem_next = wdata_q;
			end
			F_CLR: acc_next = '0;
			default: begin
			end
		endcase
	end

	assign ser_start = (state_q == ST_EXEC) && arith_go;

	smacc_mem #(
		.DEPTH(LIVE_DEPTH)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_idx (WRAP[cmd.addr]),
		.wr_en  ((state_q == ST_EXEC) && wr_en),
		.wr_idx (idx_q),
		.wr_data(wr_data),
		.rd_data(m)
	);

	smacc_serial u_serial (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ser_start),
		.op    (fn),
		.a_word(acc_q),
		.b_word(m),
		.done  (ser_done),
		.res   (ser_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && can_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					acc_q   <= acc_next;
					state_q <= arith_go ? ST_CALC : ST_DONE;
				end
				ST_CALC: begin
					if (ser_done) begin
						acc_q   <= ser_res.word;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= cmd.func;
			idx_q   <= WRAP[cmd.addr];
			wdata_q <= cmd.wdata;
		end
		if (state_q == ST_EXEC) begin
			mem_q <= mem_next;
			ovf_q <= 1'b0;
			udf_q <= 1'b0;
			dz_q  <= dz_cond;
		end
		if ((state_q == ST_CALC) && ser_done) begin
			ovf_q <= ser_res.ovf;
			udf_q <= ser_res.udf;
		end
		if ((state_q == ST_DONE) && can_load) begin
			res_q.acc_value <= acc_q;
			res_q.mem_value <= mem_q;
			res_q.overflow  <= ovf_q;
			res_q.underflow <= udf_q;
			res_q.div_zero  <= dz_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a finished command");

	a_ser_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		ser_done |-> (state_q == ST_CALC))
		else $error("arithmetic unit finished outside of the calc state");

	a_dz_keeps_acc: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EXEC) && dz_cond) |=> $stable(acc_q))
		else $error("divide by zero changed the accumulator");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ($countones({res_q.overflow, res_q.underflow, res_q.div_zero}) <= 1))
		else $error("more than one result flag set");

endmodule

// ----- src/smacc_mem.sv -----
// data memory with reset to zero, one write port and a registered read port
module smacc_mem #(
	parameter int DEPTH = 8,
	localparam int IW = $clog2(DEPTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rd_en,
	input  logic [IW-1:0]                      rd_idx,
	input  logic                               wr_en,
	input  logic [IW-1:0]                      wr_idx,
	input  logic [smacc_pkg::WORD_W-1:0]       wr_data,
	output logic [smacc_pkg::WORD_W-1:0]       rd_data
);
	import smacc_pkg::*;

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				mem_q[i] <= '0;
			end
		end else if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/smacc_serial.sv -----
// bit-serial add/sub, shift-add multiply and restoring divide on 7-bit magnitudes
module smacc_serial (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  smacc_pkg::func_t             op,
	input  logic [smacc_pkg::WORD_W-1:0] a_word,
	input  logic [smacc_pkg::WORD_W-1:0] b_word,
	output logic                         done,
	output smacc_pkg::ser_res_t          res
);
	import smacc_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	func_t            op_q;
	logic             sa_q;
	logic             sb_q;
	logic [MAG_W-1:0] a_q;
	logic [MAG_W-1:0] b_q;
	logic [MAG_W-1:0] p_q;
	logic [MAG_W-1:0] sum_q;
	logic [MAG_W-1:0] dab_q;
	logic [MAG_W-1:0] dba_q;
	logic             c_q;
	logic             bw1_q;
	logic             bw2_q;

	logic             ab;
	logic             bb;
	logic [MAG_W:0]   mul_t;
	logic [MAG_W+1:0] div_t;
	logic             q_bit;
	logic             big;
	logic             neg;
	logic             nz;
	logic [MAG_W-1:0] mag;

	assign ab    = a_q[0];
	assign bb    = b_q[0];
	assign mul_t = {1'b0, p_q} + (b_q[0] ? {1'b0, a_q} : '0);
	assign div_t = {1'b0, p_q, a_q[MAG_W-1]} - {2'b00, b_q};
	assign q_bit = !div_t[MAG_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= op;
			sa_q  <= a_word[WORD_W-1];
			sb_q  <= b_word[WORD_W-1] ^ (op == F_SUB);
			a_q   <= a_word[MAG_W-1:0];
			b_q   <= b_word[MAG_W-1:0];
			p_q   <= '0;
			c_q   <= 1'b0;
			bw1_q <= 1'b0;
			bw2_q <= 1'b0;
		end else if (busy_q) begin
			unique case (op_q)
				F_ADD, F_SUB: begin
					// sum and both differences, lsb first
					a_q   <= a_q >> 1;
					b_q   <= b_q >> 1;
					sum_q <= {ab ^ bb ^ c_q, sum_q[MAG_W-1:1]};
					c_q   <= (ab & bb) | (c_q & (ab ^ bb));
					dab_q <= {ab ^ bb ^ bw1_q, dab_q[MAG_W-1:1]};
					bw1_q <= (~ab & bb) | (~(ab ^ bb) & bw1_q);
					dba_q <= {ab ^ bb ^ bw2_q, dba_q[MAG_W-1:1]};
					bw2_q <= (~bb & ab) | (~(ab ^ bb) & bw2_q);
				end
				F_MUL: begin
					// high half in p, low half shifts into the multiplier register
					p_q <= mul_t[MAG_W:1];
					b_q <= {mul_t[0], b_q[MAG_W-1:1]};
				end
				F_DIV: begin
					// dividend leaves a msb first, quotient bits enter at the bottom
					p_q <= q_bit ? div_t[MAG_W-1:0] : {p_q[MAG_W-2:0], a_q[MAG_W-1]};
					a_q <= {a_q[MAG_W-2:0], q_bit};
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		big = 1'b0;
		neg = sa_q ^ sb_q;
		mag = a_q;
		unique case (op_q)
			F_ADD, F_SUB: begin
				if (sa_q == sb_q) begin
					big = c_q;
					mag = sum_q;
					neg = sa_q;
				end else if (!bw1_q) begin
					mag = dab_q;
					neg = sa_q;
				end else begin
					mag = dba_q;
					neg = sb_q;
				end
			end
			F_MUL: begin
				big = |p_q;
				mag = b_q;
			end
			F_DIV: begin
				mag = a_q;
			end
			default: begin
			end
		endcase
	end

	// a zero result never carries the sign bit
	assign nz       = big | (|mag);
	assign res.word = {neg & nz, mag};
	assign res.ovf  = big & ~neg;
	assign res.udf  = big & neg;
	assign done     = done_q;

endmodule

// ----- test/tb_sign_magnitude_accumulator_alu.sv -----
// testbench of the sign-magnitude accumulator alu with a self-checking shadow machine
module tb_sign_magnitude_accumulator_alu;
	import smacc_pkg::*;

	localparam int N_RANDOM   = 550;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN      = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	cmd_t pending_cmds[$];
	res_t pending_results[$];
	logic [WORD_W-1:0] acc_shadow;
	logic [WORD_W-1:0] mem_shadow[8];
	int n_total = 1;
	int n_accepted = 0;
	int n_fail = 0;
	int idle_cycles = 0;

	sign_magnitude_accumulator_alu i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int sm_val(input logic [WORD_W-1:0] w);
		int mag;
		mag = int'(w[MAG_W-1:0]);
		return w[WORD_W-1] ? -mag : mag;
	endfunction

	// magnitude wraps modulo 128, sign only for a negative result
	function automatic logic [WORD_W-1:0] sm_pack(input int v, output logic ovf,
			output logic udf);
		int mag;
		ovf = (v > 127);
		udf = (v < -127);
		mag = (v < 0) ? -v : v;
		return {(v < 0), mag[MAG_W-1:0]};
	endfunction

	function automatic res_t execute_step(input cmd_t c);
		res_t r;
		int a;
		int b;
		logic ovf;
		logic udf;
		logic dz;
		logic [WORD_W-1:0] m;
		m = mem_shadow[c.addr];
		a = sm_val(acc_shadow);
		b = sm_val(m);
		ovf = 1'b0;
		udf = 1'b0;
		dz = 1'b0;
		case (c.func)
			F_ADD: acc_shadow = sm_pack(a + b, ovf, udf);
			F_SUB: acc_shadow = sm_pack(a - b, ovf, udf);
			F_MUL: acc_shadow = sm_pack(a * b, ovf, udf);
			F_DIV: begin
				if (b == 0)
					dz = 1'b1;
				else
					acc_shadow = sm_pack(a / b, ovf, udf);
			end
			F_AND: acc_shadow = acc_shadow & m;
			F_NOT: acc_shadow = ~acc_shadow;
			F_OR:  acc_shadow = acc_shadow | m;
			F_XOR: acc_shadow = acc_shadow ^ m;
			F_LD:  acc_shadow = m;
			F_ST:  mem_shadow[c.addr] = acc_shadow;
			F_WR:  mem_shadow[c.addr] = c.wdata;
			F_CLR: acc_shadow = '0;
			default: ;
		endcase
		r.acc_value = acc_shadow;
		r.mem_value = mem_shadow[c.addr];
		r.overflow = ovf;
		r.underflow = udf;
		r.div_zero = dz;
		return r;
	endfunction

	function automatic cmd_t make_cmd(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
			input logic [WORD_W-1:0] d);
		cmd_t c;
		c.func = f;
		c.addr = a;
		c.wdata = d;
		return c;
	endfunction

	// first third: sender idles lightly, receiver heavily; then swapped; then no idling
	function automatic int idle_pct(input bit sender);
		int phase;
		phase = (n_accepted * 3) / n_total;
		if (phase == 0)
			return sender ? 15 : 69;
		else if (phase == 1)
			return sender ? 69 : 15;
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			res_stall <= 1'b0;
		end else begin
			if (!cmd_valid || !cmd_stall) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
					cmd <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
			res_stall <= ($urandom_range(99) < idle_pct(1'b0));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				pending_results.push_back(execute_step(cmd));
				n_accepted <= n_accepted + 1;
			end
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with no expected result: %h", res);
					n_fail = n_fail + 1;
				end else begin
					res_t want;
					want = pending_results.pop_front();
					if (res.acc_value !== want.acc_value) begin
						$error("acc_value: expected %h, got %h", want.acc_value, res.acc_value);
						n_fail = n_fail + 1;
					end
					if (res.mem_value !== want.mem_value) begin
						$error("mem_value: expected %h, got %h", want.mem_value, res.mem_value);
						n_fail = n_fail + 1;
					end
					if (res.overflow !== want.overflow) begin
						$error("overflow: expected %b, got %b", want.overflow, res.overflow);
						n_fail = n_fail + 1;
					end
					if (res.underflow !== want.underflow) begin
						$error("underflow: expected %b, got %b", want.underflow, res.underflow);
						n_fail = n_fail + 1;
					end
					if (res.div_zero !== want.div_zero) begin
						$error("div_zero: expected %b, got %b", want.div_zero, res.div_zero);
						n_fail = n_fail + 1;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int r;
		acc_shadow = '0;
		foreach (mem_shadow[i])
			mem_shadow[i] = '0;

		// directed: extreme words, negative zero, wrap, flags, every opcode
		pending_cmds.push_back(make_cmd(F_LD, 3'd4, 8'h00));
		pending_cmds.push_back(make_cmd(F_WR, 3'd0, 8'h7F));
		pending_cmds.push_back(make_cmd(F_WR, 3'd7, 8'h80));
		pending_cmds.push_back(make_cmd(F_WR, 3'd1, 8'hFF));
		pending_cmds.push_back(make_cmd(F_WR, 3'd2, 8'h00));
		pending_cmds.push_back(make_cmd(F_LD, 3'd0, 8'hA5));
		pending_cmds.push_back(make_cmd(F_ADD, 3'd0, 8'h5A));
		pending_cmds.push_back(make_cmd(F_LD, 3'd1, 8'h00));
		pending_cmds.push_back(make_cmd(F_ADD, 3'd1, 8'h00));
		pending_cmds.push_back(make_cmd(F_LD, 3'd0, 8'h00));
		pending_cmds.push_back(make_cmd(F_SUB, 3'd1, 8'h00));
		pending_cmds.push_back(make_cmd(F_MUL, 3'd1, 8'h00));
		pending_cmds.push_back(make_cmd(F_DIV, 3'd7, 8'h00));
		pending_cmds.push_back(make_cmd(F_DIV, 3'd2, 8'h00));
		pending_cmds.push_back(make_cmd(F_LD, 3'd0, 8'h00));
		pending_cmds.push_back(make_cmd(F_DIV, 3'd1, 8'h00));
		pending_cmds.push_back(make_cmd(F_SUB, 3'd1, 8'h00));
		pending_cmds.push_back(make_cmd(F_AND, 3'd1, 8'h00));
		pending_cmds.push_back(make_cmd(F_OR, 3'd7, 8'h00));
		pending_cmds.push_back(make_cmd(F_XOR, 3'd0, 8'h00));
		pending_cmds.push_back(make_cmd(F_NOT, 3'd5, 8'h00));
		pending_cmds.push_back(make_cmd(F_ST, 3'd3, 8'h00));
		pending_cmds.push_back(make_cmd(F_LD, 3'd7, 8'h00));
		pending_cmds.push_back(make_cmd(F_ADD, 3'd2, 8'h00));
		pending_cmds.push_back(make_cmd(F_CLR, 3'd6, 8'hFF));
		pending_cmds.push_back(make_cmd(4'd12, 3'd0, 8'hFF));
		pending_cmds.push_back(make_cmd(4'd15, 3'd7, 8'h00));

		// random: bias toward memory writes and loads to keep operands varied
		repeat (N_RANDOM) begin
			r = $urandom_range(99);
			if (r < 20)
				pending_cmds.push_back(make_cmd(F_WR, 3'($urandom_range(7)),
					8'($urandom_range(255))));
			else if (r < 30)
				pending_cmds.push_back(make_cmd(F_LD, 3'($urandom_range(7)),
					8'($urandom_range(255))));
			else if (r < 34)
				pending_cmds.push_back(make_cmd(4'($urandom_range(15, 12)),
					3'($urandom_range(7)), 8'($urandom_range(255))));
			else
				pending_cmds.push_back(make_cmd(4'($urandom_range(11)),
					3'($urandom_range(7)), 8'($urandom_range(255))));
		end
		n_total = pending_cmds.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_total || pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (n_fail == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
src/smacc_pkg.sv
src/smacc_mem.sv
src/smacc_serial.sv
src/sign_magnitude_accumulator_alu.sv
test/tb_sign_magnitude_accumulator_alu.sv
